>>> rtl/scan_correspondence_overlap_top_assert.svh
// assertion macros for the scan correspondence overlap block
`ifndef SCAN_CORRESPONDENCE_OVERLAP_TOP_ASSERT_SVH
`define SCAN_CORRESPONDENCE_OVERLAP_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication, checked outside reset
`define SCO_ASSERT_NOW(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);
// next-cycle implication, checked outside reset
`define SCO_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);
`else
`define SCO_ASSERT_NOW(lbl, ant, cons, msg)
`define SCO_ASSERT_NEXT(lbl, ant, cons, msg)
`endif
`endif

>>> rtl/sco_pkg.sv
// shared types and constants for the scan correspondence overlap block
package sco_pkg;

	localparam int MAX_RAYS_DEF = 2048;
	localparam int IDX_W        = 11;
	localparam int CNT_OUT_W    = 12;
	localparam int MARGIN_W     = 6;
	localparam int MINOV_W      = 12;
	localparam int ENTRY_W      = IDX_W + 1;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 12;

	localparam logic [MARGIN_W-1:0]  MARGIN_RST = MARGIN_W'(5);
	localparam logic [MINOV_W-1:0]   MINOV_RST  = MINOV_W'(5);
	localparam logic [CNT_OUT_W-1:0] CNT_SAT    = {CNT_OUT_W{1'b1}};

	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_SMALL = 2'd1,
		FUNC_LINE  = 2'd2
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_MARGIN = 1'b0,
		REG_MIN_OVERLAP   = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FLUSH,
		S_DONE
	} state_t;

endpackage

>>> rtl/scan_correspondence_overlap_top.sv
// scan correspondence overlap: match table memory, loader and range queries
//
// Input channel (in_valid / in_stall) carries one item per beat: a load
// (func 0) appends one table entry, or flags overflow if the table is full,
// a small-segment query (func 1) or a line query (func 2) scans a range of
// the table. Every item gives exactly one result beat on the output channel
// (out_valid / out_stall). Config writes go through cfg_valid / cfg_ready /
// cfg_index / cfg_data; cfg_ready is always high, writes belong in idle time
// with no item in flight. With restart, a load starts the table anew at
// slot 0. A load or an empty query goes straight to the done state; a
// non-empty query first steps through the scan and flush states, since the
// single read port of the table memory is stepped one entry per cycle and
// the read data arrives in the cycle after the address. One item is worked
// on at a time; the next input beat is taken as soon as the previous result
// has moved into the output register, even while the receiver stalls it. A
// stalled result holds its value.
// Reset empties the table (entry count zero), sets window_margin and
// min_overlap to 5 and drops any pending result. The table memory itself
// is not cleared: entries are read only below the entry count.
`include "scan_correspondence_overlap_top_assert.svh"

module scan_correspondence_overlap_top #(
	parameter int MAX_RAYS = sco_pkg::MAX_RAYS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// config port
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sco_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sco_pkg::CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     func,
	input  logic                           restart,
	input  logic                           entry_valid,
	input  logic [sco_pkg::IDX_W-1:0]      entry_match,
	input  logic [sco_pkg::IDX_W-1:0]      seg1_start,
	input  logic [sco_pkg::IDX_W-1:0]      seg1_end,
	input  logic [sco_pkg::IDX_W-1:0]      seg2_start,
	input  logic [sco_pkg::IDX_W-1:0]      seg2_end,
	// output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           overlap,
	output logic [sco_pkg::CNT_OUT_W-1:0]  match_count,
	output logic                           overflow
);

	localparam int AW = $clog2(MAX_RAYS);
	localparam int CW = $clog2(MAX_RAYS + 1);
	localparam int XW = (CW > sco_pkg::CNT_OUT_W) ? CW : sco_pkg::CNT_OUT_W;

	// config registers
	logic [sco_pkg::MARGIN_W-1:0] margin_q;
	logic [sco_pkg::MINOV_W-1:0]  min_ov_q;

	// control state
	sco_pkg::state_t state_q, state_d;
	logic [CW-1:0]   entry_count_q;
	logic            out_valid_q;
	logic            rd_vld_s1;

	// query registers
	logic [XW-1:0]             addr_q;
	logic [XW-1:0]             hi_q;
	logic [XW-1:0]             span_q;
	logic [sco_pkg::IDX_W-1:0] s2lo_q;
	logic [sco_pkg::IDX_W-1:0] s2hi_q;
	logic [CW-1:0]             cnt_q;
	sco_pkg::func_t            func_q;
	logic                      ovf_q;

	// output registers
	logic                          overlap_q;
	logic [sco_pkg::CNT_OUT_W-1:0] count_q;
	logic                          overflow_q;

	// table memory
	logic [sco_pkg::ENTRY_W-1:0] mem [MAX_RAYS];
	logic [sco_pkg::ENTRY_W-1:0] rd_data_s1;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [sco_pkg::ENTRY_W-1:0] wr_data;
	logic [AW-1:0]               rd_addr;

	logic                          in_acc;
	logic                          out_free;
	logic [CW-1:0]                 wr_idx;
	logic                          full_c;
	logic [XW-1:0]                 lo_c, hi_raw_c, hi_c, ec_last_c;
	logic                          empty_c;
	logic                          hit_c;
	logic                          last_c;
	logic                          overlap_c;
	logic [sco_pkg::CNT_OUT_W-1:0] count_c;

	assign cfg_ready   = 1'b1;
	assign in_stall    = (state_q != sco_pkg::S_IDLE);
	assign in_acc      = in_valid && !in_stall;
	assign out_free    = !out_valid_q || !out_stall;
	assign out_valid   = out_valid_q;
	assign overlap     = overlap_q;
	assign match_count = count_q;
	assign overflow    = overflow_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= sco_pkg::MARGIN_RST;
			min_ov_q <= sco_pkg::MINOV_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sco_pkg::REG_WINDOW_MARGIN: margin_q <= cfg_data[sco_pkg::MARGIN_W-1:0];
				sco_pkg::REG_MIN_OVERLAP:   min_ov_q <= cfg_data[sco_pkg::MINOV_W-1:0];
				default: ;
			endcase
		end
	end

	// load slot and full check
	always_comb begin
		wr_idx  = restart ? '0 : entry_count_q;
		full_c  = (XW'(wr_idx) >= XW'(MAX_RAYS));
		wr_en   = in_acc && (func == sco_pkg::FUNC_LOAD) && !full_c;
		wr_addr = wr_idx[AW-1:0];
		wr_data = entry_valid ? {1'b1, entry_match} : '0;
	end

	// query range: widen for small segments, clamp to filled table
	always_comb begin
		ec_last_c = XW'(entry_count_q) - XW'(1);
		if (func == sco_pkg::FUNC_SMALL) begin
			lo_c     = (XW'(seg1_start) >= XW'(margin_q)) ?
			           XW'(seg1_start) - XW'(margin_q) : '0;
			hi_raw_c = XW'(seg1_end) + XW'(margin_q);
		end else begin
			lo_c     = XW'(seg1_start);
			hi_raw_c = XW'(seg1_end);
		end
		hi_c    = (hi_raw_c > ec_last_c) ? ec_last_c : hi_raw_c;
		empty_c = (entry_count_q == '0) || (hi_c < lo_c);
	end

	// next state
	always_comb begin
		state_d = state_q;
		last_c  = (addr_q == hi_q);
		rd_addr = addr_q[AW-1:0];
		case (state_q)
			sco_pkg::S_IDLE: begin
				if (in_acc) begin
					case (func)
						sco_pkg::FUNC_SMALL, sco_pkg::FUNC_LINE:
							state_d = empty_c ? sco_pkg::S_DONE : sco_pkg::S_SCAN;
						default: state_d = sco_pkg::S_DONE;
					endcase
				end
			end
			sco_pkg::S_SCAN: begin
				if (last_c) state_d = sco_pkg::S_FLUSH;
			end
			sco_pkg::S_FLUSH: state_d = sco_pkg::S_DONE;
			sco_pkg::S_DONE: begin
				if (out_free) state_d = sco_pkg::S_IDLE;
			end
			default: state_d = sco_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sco_pkg::S_IDLE;
		else         state_q <= state_d;
	end

	// table memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data_s1 <= mem[rd_addr];
	end

	// entry count and read-valid pipeline flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			rd_vld_s1     <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == sco_pkg::S_SCAN);
			if (in_acc && (func == sco_pkg::FUNC_LOAD) && !full_c)
				entry_count_q <= wr_idx + CW'(1);
		end
	end

	// match test on returning read data
	assign hit_c = rd_vld_s1 && rd_data_s1[sco_pkg::ENTRY_W-1] &&
	               (rd_data_s1[sco_pkg::IDX_W-1:0] >= s2lo_q) &&
	               (rd_data_s1[sco_pkg::IDX_W-1:0] <= s2hi_q);

	// query bookkeeping and match counter
	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_q <= lo_c;
			hi_q   <= hi_c;
			span_q <= empty_c ? '0 : hi_c - lo_c;
			s2lo_q <= seg2_start;
			s2hi_q <= seg2_end;
			cnt_q  <= '0;
			func_q <= sco_pkg::func_t'(func);
			ovf_q  <= (func == sco_pkg::FUNC_LOAD) && full_c;
		end else begin
			if (state_q == sco_pkg::S_SCAN && !last_c) addr_q <= addr_q + XW'(1);
			if (hit_c) cnt_q <= cnt_q + CW'(1);
		end
	end

	// result fields from the finished count
	always_comb begin
		count_c = (XW'(cnt_q) > XW'(sco_pkg::CNT_SAT)) ? sco_pkg::CNT_SAT
		          : sco_pkg::CNT_OUT_W'(XW'(cnt_q));
		case (func_q)
			sco_pkg::FUNC_SMALL: overlap_c = (cnt_q != '0);
			sco_pkg::FUNC_LINE:
				overlap_c = (XW'(cnt_q) > XW'(min_ov_q)) &&
				            (((XW+1)'(cnt_q) << 1) > (XW+1)'(span_q));
			default: overlap_c = 1'b0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == sco_pkg::S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sco_pkg::S_DONE && out_free) begin
			overlap_q  <= overlap_c;
			count_q    <= count_c;
			overflow_q <= ovf_q;
		end
	end

	// checks
	`SCO_ASSERT_NOW(a_count_bound, 1'b1, XW'(entry_count_q) <= XW'(MAX_RAYS),
		"entry count above table size")
	`SCO_ASSERT_NOW(a_scan_in_range, state_q == sco_pkg::S_SCAN, addr_q <= hi_q,
		"scan address past range end")
	`SCO_ASSERT_NEXT(a_read_follows_scan, state_q == sco_pkg::S_SCAN, rd_vld_s1,
		"read data flag missing after scan cycle")

endmodule

>>> sim/tb.sv
// self-checking testbench for the scan correspondence overlap block
module tb;
	import sco_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int IDLE_TAIL = 10;

	typedef struct packed {
		logic [1:0]       func;
		logic             restart;
		logic             entry_valid;
		logic [IDX_W-1:0] entry_match;
		logic [IDX_W-1:0] seg1_start;
		logic [IDX_W-1:0] seg1_end;
		logic [IDX_W-1:0] seg2_start;
		logic [IDX_W-1:0] seg2_end;
	} ray_item_t;

	typedef struct packed {
		logic                 overlap;
		logic [CNT_OUT_W-1:0] match_count;
		logic                 overflow;
	} overlap_result_t;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	// correspondence table predictor and queue of expected answers
	class overlap_scoreboard;
		logic [ENTRY_W-1:0] corr_entries [MAX_RAYS_DEF];
		int entry_total;
		int margin;
		int min_hits;
		overlap_result_t expected_q [$];
		int errors;

		function new();
			entry_total = 0;
			margin = MARGIN_RST;
			min_hits = MINOV_RST;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_WINDOW_MARGIN) begin
				margin = data[MARGIN_W-1:0];
			end else begin
				min_hits = data[MINOV_W-1:0];
			end
		endfunction

		// valid matches in [s2lo, s2hi] over table entries lo..hi, clamped to the fill
		function int count_hits(int lo, int hi, int s2lo, int s2hi);
			int n;
			logic [ENTRY_W-1:0] e;
			n = 0;
			if (lo < 0)
				lo = 0;
			if (hi > entry_total - 1)
				hi = entry_total - 1;
			for (int i = lo; i <= hi; i++) begin
				e = corr_entries[i];
				if (e[IDX_W] && e[IDX_W-1:0] >= s2lo && e[IDX_W-1:0] <= s2hi)
					n++;
			end
			return n;
		endfunction

		// accepted input beat: update table, queue the answer
		function void note_item(ray_item_t it);
			overlap_result_t r;
			int hits;
			int lo;
			int hi;
			r = '0;
			case (it.func)
			FUNC_LOAD: begin
				if (it.restart)
					entry_total = 0;
				if (entry_total >= MAX_RAYS_DEF) begin
					r.overflow = 1'b1;
				end else begin
					corr_entries[entry_total] = it.entry_valid ? {1'b1, it.entry_match} : '0;
					entry_total++;
				end
			end
			FUNC_SMALL: begin
				hits = count_hits(int'(it.seg1_start) - margin, int'(it.seg1_end) + margin,
					it.seg2_start, it.seg2_end);
				r.match_count = CNT_OUT_W'(hits);
				r.overlap = (hits != 0);
			end
			FUNC_LINE: begin
				lo = it.seg1_start;
				hi = it.seg1_end;
				if (hi > entry_total - 1)
					hi = entry_total - 1;
				hits = count_hits(lo, hi, it.seg2_start, it.seg2_end);
				r.match_count = (hits > CNT_SAT) ? CNT_SAT : CNT_OUT_W'(hits);
				r.overlap = (hits > min_hits) && (2 * hits > hi - lo);
			end
			default: ;
			endcase
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		// accepted output beat against the oldest expectation
		task check_result(overlap_result_t got);
			overlap_result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result with nothing pending: overlap %0d count %0d overflow %0d",
					got.overlap, got.match_count, got.overflow));
				return;
			end
			want = expected_q.pop_front();
			if (got.overlap !== want.overlap)
				report($sformatf("overlap got %0d want %0d", got.overlap, want.overlap));
			if (got.match_count !== want.match_count)
				report($sformatf("match_count got %0d want %0d", got.match_count, want.match_count));
			if (got.overflow !== want.overflow)
				report($sformatf("overflow got %0d want %0d", got.overflow, want.overflow));
		endtask

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            func;
	logic                  restart;
	logic                  entry_valid;
	logic [IDX_W-1:0]      entry_match;
	logic [IDX_W-1:0]      seg1_start;
	logic [IDX_W-1:0]      seg1_end;
	logic [IDX_W-1:0]      seg2_start;
	logic [IDX_W-1:0]      seg2_end;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  overlap;
	logic [CNT_OUT_W-1:0]  match_count;
	logic                  overflow;

	overlap_scoreboard sb;
	int burst_left;
	stall_mode_t stall_mode = STALL_NONE;
	int stall_left = 0;
	int stall_tick = 0;

	scan_correspondence_overlap_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.restart     (restart),
		.entry_valid (entry_valid),
		.entry_match (entry_match),
		.seg1_start  (seg1_start),
		.seg1_end    (seg1_end),
		.seg2_start  (seg2_start),
		.seg2_end    (seg2_end),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.overlap     (overlap),
		.match_count (match_count),
		.overflow    (overflow)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// beat monitors on all three channels
	always @(posedge clk) begin
		ray_item_t seen;
		overlap_result_t got;
		if (arst_n && in_valid && !in_stall) begin
			seen = {func, restart, entry_valid, entry_match,
				seg1_start, seg1_end, seg2_start, seg2_end};
			sb.note_item(seen);
		end
		if (arst_n && out_valid && !out_stall) begin
			got = {overlap, match_count, overflow};
			sb.check_result(got);
		end
		if (arst_n && cfg_valid && cfg_ready)
			sb.write_reg(cfg_index, cfg_data);
	end

	// receiver back-pressure: a random mode, redrawn when its countdown runs out
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(64, 256);
		end else begin
			stall_left <= stall_left - 1;
		end
		stall_tick <= stall_tick + 1;
		case (stall_mode)
		STALL_NONE:  out_stall <= 1'b0;
		STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
		STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
		default:     out_stall <= ((stall_tick % 7) < 3);
		endcase
	end

	function automatic ray_item_t rand_item();
		ray_item_t it;
		it.func        = 2'($urandom_range(0, 3));
		it.restart     = 1'($urandom_range(0, 1));
		it.entry_valid = 1'($urandom_range(0, 1));
		it.entry_match = IDX_W'($urandom_range(0, 2047));
		it.seg1_start  = IDX_W'($urandom_range(0, 2047));
		it.seg1_end    = IDX_W'($urandom_range(0, 2047));
		it.seg2_start  = IDX_W'($urandom_range(0, 2047));
		it.seg2_end    = IDX_W'($urandom_range(0, 2047));
		return it;
	endfunction

	function automatic ray_item_t load_item(logic rst, logic vld, int match);
		ray_item_t it;
		it = rand_item();
		it.func        = FUNC_LOAD;
		it.restart     = rst;
		it.entry_valid = vld;
		it.entry_match = match[IDX_W-1:0];
		return it;
	endfunction

	function automatic ray_item_t seg_query(logic [1:0] f, int a, int b, int c, int d);
		ray_item_t it;
		it = rand_item();
		it.func       = f;
		it.seg1_start = IDX_W'(a);
		it.seg1_end   = IDX_W'(b);
		it.seg2_start = IDX_W'(c);
		it.seg2_end   = IDX_W'(d);
		return it;
	endfunction

	// query aimed at a table of len entries whose matches run near base
	function automatic ray_item_t make_query(int len, int base);
		int s1s;
		int s1e;
		int s2s;
		int s2e;
		int k;
		s1s = $urandom_range(0, len + 8);
		if (s1s > 2047)
			s1s = 2047;
		k = $urandom_range(0, 19);
		if (k < 14)
			s1e = s1s + $urandom_range(0, 40);
		else if (k < 17)
			s1e = s1s + $urandom_range(41, 300);
		else if (k < 18)
			s1e = s1s - $urandom_range(1, 10);
		else
			s1e = 2047;
		if (s1e < 0)
			s1e = 0;
		if (s1e > 2047)
			s1e = 2047;
		s2s = base + s1s - $urandom_range(0, 12);
		if ($urandom_range(0, 9) == 0)
			s2e = s2s - $urandom_range(1, 20);
		else
			s2e = s2s + $urandom_range(0, 70);
		return seg_query($urandom_range(0, 1) ? FUNC_SMALL : FUNC_LINE,
			s1s, s1e, s2s[IDX_W-1:0], s2e[IDX_W-1:0]);
	endfunction

	// one input beat, then the sender's burst and gap pattern
	task automatic send_item(ray_item_t it);
		int gap;
		func        <= it.func;
		restart     <= it.restart;
		entry_valid <= it.entry_valid;
		entry_match <= it.entry_match;
		seg1_start  <= it.seg1_start;
		seg1_end    <= it.seg1_end;
		seg2_start  <= it.seg2_start;
		seg2_end    <= it.seg2_end;
		in_valid    <= 1'b1;
		do @(posedge clk); while (in_stall);
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
		end
	endtask

	// drain all pending answers and let the block settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (IDLE_TAIL) @(posedge clk);
	endtask

	task automatic write_config(logic [CFG_DATA_W-1:0] margin_d, logic [CFG_DATA_W-1:0] minov_d);
		cfg_valid <= 1'b1;
		cfg_index <= REG_WINDOW_MARGIN;
		cfg_data  <= margin_d;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_MIN_OVERLAP;
		cfg_data  <= minov_d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_phase(int k);
		case (k % 4)
		0:       write_config(0, 0);
		1:       write_config(63, 2048);
		2:       write_config(CFG_DATA_W'($urandom_range(0, 4095)),
		                      CFG_DATA_W'($urandom_range(0, 4095)));
		default: write_config(CFG_DATA_W'($urandom_range(1, 12)),
		                      CFG_DATA_W'($urandom_range(2, 40)));
		endcase
	endtask

	// hard stop if the block hangs
	initial begin
		#20000000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		ray_item_t it;
		int len;
		int base;
		int nq;
		int k;
		int pick;
		int n_rand;
		int next_cfg;
		int phase;
		int tab_len;

		sb = new();
		burst_left = 1;
		arst_n      <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= REG_WINDOW_MARGIN;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		func        <= FUNC_LOAD;
		restart     <= 1'b0;
		entry_valid <= 1'b0;
		entry_match <= '0;
		seg1_start  <= '0;
		seg1_end    <= '0;
		seg2_start  <= '0;
		seg2_end    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, unused func, extremes, clamping, thresholds
		send_item(seg_query(FUNC_LINE, 0, 2047, 0, 2047));
		send_item(seg_query(FUNC_SMALL, 0, 2047, 0, 2047));
		it = rand_item();
		it.func = FUNC_UNUSED;
		send_item(it);
		send_item(load_item(1'b0, 1'b1, 0));
		send_item(load_item(1'b0, 1'b1, 2047));
		send_item(load_item(1'b0, 1'b0, 2047));
		for (int i = 0; i < 10; i++)
			send_item(load_item(1'b0, 1'b1, 100 + i));
		send_item(seg_query(FUNC_SMALL, 0, 0, 0, 2047));
		send_item(seg_query(FUNC_SMALL, 2047, 2047, 0, 2047));
		send_item(seg_query(FUNC_LINE, 5, 1, 0, 2047));
		send_item(seg_query(FUNC_LINE, 0, 2047, 110, 100));
		send_item(seg_query(FUNC_SMALL, 0, 2047, 110, 100));
		send_item(seg_query(FUNC_LINE, 0, 2047, 0, 2047));
		send_item(seg_query(FUNC_LINE, 3, 12, 100, 105));
		send_item(seg_query(FUNC_LINE, 3, 12, 100, 104));
		send_item(load_item(1'b1, 1'b1, 7));
		send_item(seg_query(FUNC_SMALL, 0, 2047, 7, 7));

		// random: short scans followed by queries, noise, scan extensions
		tab_len = 1;
		base = 7;
		n_rand = 0;
		next_cfg = 0;
		phase = 0;
		while (n_rand < 100) begin
			if (n_rand >= next_cfg) begin
				wait_idle();
				apply_phase(phase);
				phase++;
				next_cfg += 25;
			end
			pick = $urandom_range(0, 99);
			if (pick < 78) begin
				len = ($urandom_range(0, 6) == 0) ? $urandom_range(31, 60) : $urandom_range(8, 30);
				base = $urandom_range(0, 2047);
				for (int i = 0; i < len; i++)
					send_item(load_item(i == 0, $urandom_range(0, 9) != 0,
						base + i + $urandom_range(0, 3)));
				tab_len = len;
				nq = $urandom_range(4, 10);
				repeat (nq) send_item(make_query(tab_len, base));
				n_rand += len + nq;
			end else if (pick < 90) begin
				// noise: any func, any field, restarts mid-scan
				repeat ($urandom_range(1, 6)) begin
					it = rand_item();
					if (it.func == FUNC_LOAD)
						tab_len = it.restart ? 1 : tab_len + 1;
					send_item(it);
					n_rand++;
				end
			end else begin
				// scan extended without restart
				k = $urandom_range(1, 20);
				repeat (k) begin
					send_item(load_item(1'b0, $urandom_range(0, 1), base + tab_len + $urandom_range(0, 3)));
					tab_len++;
				end
				repeat (2) send_item(make_query(tab_len, base));
				n_rand += k + 2;
			end
		end

		// full table built as one long scan with queries along the way
		wait_idle();
		write_config(CFG_DATA_W'($urandom_range(0, 63)), 1000);
		base = $urandom_range(0, 2047);
		for (int i = 0; i < MAX_RAYS_DEF; i++) begin
			send_item(load_item(i == 0, $urandom_range(0, 9) != 0,
				base + i + $urandom_range(0, 3)));
			if (i % 512 == 511)
				repeat (2) send_item(make_query(i + 1, base));
		end

		// full table: overflow, whole-table queries, restart while full
		repeat (3) send_item(load_item(1'b0, $urandom_range(0, 1), $urandom_range(0, 2047)));
		send_item(seg_query(FUNC_LINE, 0, 2047, 0, 2047));
		send_item(seg_query(FUNC_SMALL, 0, 2047, 0, 2047));
		send_item(seg_query(FUNC_LINE, 1000, 2047, 300, 1700));
		repeat (6) send_item(make_query(MAX_RAYS_DEF, base));
		wait_idle();
		write_config(63, 2048);
		send_item(seg_query(FUNC_LINE, 0, 2047, 0, 2047));
		send_item(load_item(1'b1, 1'b1, 2047));
		send_item(seg_query(FUNC_SMALL, 0, 0, 2047, 2047));

		wait_idle();
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/sco_pkg.sv
rtl/scan_correspondence_overlap_top.sv
sim/tb.sv
